// ===== rtl/core/mtsl_pkg.sv =====
// Package for the two-list merge block: widths, command codes, the queue word.
// Used by every module under rtl/core; depends on nothing else.
package mtsl_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 2;

    // Command codes on the input port
    localparam logic [CMD_W-1:0] CMD_PUSH_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE       = 2'd2;

    // Operation held in the queue after decode
    typedef enum logic [1:0] {
        OP_PUSH_FIRST,
        OP_PUSH_SECOND,
        OP_MERGE
    } op_t;

    // One queued word: the decoded operation and its operand
    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } qword_t;

endpackage

// ===== rtl/core/mtsl_front.sv =====
// Front end: decodes accepted commands and holds them in a two-word queue.
// Depends on mtsl_pkg.
module mtsl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      command,
    input  logic [31:0]     value,
    output logic            busy,
    output logic            q_valid,
    output mtsl_pkg::qword_t q_word,
    input  logic            q_pop
);
    import mtsl_pkg::*;

    qword_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    logic   full;
    logic   keep;
    qword_t dec_word;
    logic   do_push;
    logic   do_pop;

    assign full    = (fill_reg == 2'd2);
    assign busy    = full;
    assign q_valid = (fill_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];

    // Classify; drop the unused code here
    always_comb
    begin
        dec_word.value = value;
        dec_word.op    = OP_MERGE;
        keep           = 1'b1;
        case (command)
            CMD_PUSH_FIRST:  dec_word.op = OP_PUSH_FIRST;
            CMD_PUSH_SECOND: dec_word.op = OP_PUSH_SECOND;
            CMD_MERGE:       dec_word.op = OP_MERGE;
            default:         keep        = 1'b0;
        endcase
    end

    assign do_push = start && !full && keep;
    assign do_pop  = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 2'd1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= dec_word;
    end

endmodule

// ===== rtl/core/mtsl_back.sv =====
// Back end: holds both lists and their counts, runs pushes and the merge walk.
// Depends on mtsl_pkg.
module mtsl_back #(
    parameter int DEPTH = mtsl_pkg::DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  mtsl_pkg::qword_t        q_word,
    output logic                    q_pop,
    output logic                    valid,
    output logic signed [31:0]      merged_value,
    output logic                    from_second,
    output logic                    last
);
    import mtsl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    logic signed [VALUE_W-1:0] a_mem [DEPTH];
    logic signed [VALUE_W-1:0] b_mem [DEPTH];
    logic signed [VALUE_W-1:0] a_rd_reg;
    logic signed [VALUE_W-1:0] b_rd_reg;

    state_t  state_reg, state_next;
    logic [CW-1:0] a_cnt_reg, a_cnt_next;
    logic [CW-1:0] b_cnt_reg, b_cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      src_reg, src_next;
    logic                      last_reg, last_next;

    logic a_has;
    logic b_has;
    logic take_a;
    logic run_end;
    logic a_wr;
    logic b_wr;

    assign q_pop = q_valid && (state_reg == ST_IDLE);
    assign a_wr  = q_pop && (q_word.op == OP_PUSH_FIRST)  && (a_cnt_reg < CW'(DEPTH));
    assign b_wr  = q_pop && (q_word.op == OP_PUSH_SECOND) && (b_cnt_reg < CW'(DEPTH));

    assign a_has   = (i_reg < a_cnt_reg);
    assign b_has   = (j_reg < b_cnt_reg);
    assign take_a  = a_has && (!b_has || (a_rd_reg < b_rd_reg));
    assign run_end = (({1'b0, i_reg} + {1'b0, j_reg} + (CW+1)'(1))
                      == ({1'b0, a_cnt_reg} + {1'b0, b_cnt_reg}));

    always_comb
    begin
        state_next = state_reg;
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        valid_next = 1'b0;
        value_next = value_reg;
        src_next   = src_reg;
        last_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (a_wr)
                    a_cnt_next = a_cnt_reg + CW'(1);
                if (b_wr)
                    b_cnt_next = b_cnt_reg + CW'(1);
                if (q_pop && (q_word.op == OP_MERGE)
                    && ((a_cnt_reg != '0) || (b_cnt_reg != '0)))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // Emit the smaller head; a tie goes to the second list
                valid_next = 1'b1;
                value_next = take_a ? a_rd_reg : b_rd_reg;
                src_next   = !take_a;
                last_next  = run_end;
                if (take_a)
                    i_next = i_reg + CW'(1);
                else
                    j_next = j_reg + CW'(1);
                if (run_end)
                begin
                    state_next = ST_IDLE;
                    a_cnt_next = '0;
                    b_cnt_next = '0;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            valid_reg <= 1'b0;
            value_reg <= '0;
            src_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            valid_reg <= valid_next;
            value_reg <= value_next;
            src_reg   <= src_next;
            last_reg  <= last_next;
        end
    end

    // List storage; read the next heads into registers so they are ready in the next cycle
    always_ff @(posedge clk)
    begin
        if (a_wr)
            a_mem[a_cnt_reg[IW-1:0]] <= q_word.value;
        if (b_wr)
            b_mem[b_cnt_reg[IW-1:0]] <= q_word.value;
        a_rd_reg <= a_mem[i_next[IW-1:0]];
        b_rd_reg <= b_mem[j_next[IW-1:0]];
    end

    assign valid        = valid_reg;
    assign merged_value = value_reg;
    assign from_second  = src_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/merge_two_sorted_lists_top.sv =====
// Top level of the two-list merge block: front decode queue plus back execution unit.
// Depends on mtsl_pkg, mtsl_front and mtsl_back.
//
// A word is taken at a rising edge with start high and busy low. Commands: push to the
// first list, push to the second list, merge. Words pass through a two-word queue, so the
// front keeps taking words while the back is working; busy is high only while that queue
// holds two words. The back unit takes a push while idle, so pushes sustain one per cycle
// while no merge runs. A merge of n stored values emits n results on consecutive cycles,
// one per cycle; popping the merge word moves the back to its run state, which registers
// the first result. The list memories, read once per cycle at the next head, set that pace.
// While a merge runs the queue does not drain, so at most two more words are taken.
// Each result is marked by valid for exactly one cycle and cannot be held off: capture it
// on that cycle. last marks the final result of a merge; a merge of two empty lists emits
// nothing. Ties go to the second list first. Pushes to a full list and the unused command
// code are dropped without a trace. Both lists empty after each merge.
module merge_two_sorted_lists_top #(
    parameter int DEPTH = mtsl_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               valid,
    output logic signed [31:0] merged_value,
    output logic               from_second,
    output logic               last
);
    import mtsl_pkg::*;

    logic   q_valid;
    logic   q_pop;
    qword_t q_word;

    // Decode and buffer incoming words
    mtsl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .value   (value),
        .busy    (busy),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    // Store lists and run the merge walk
    mtsl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop),
        .valid        (valid),
        .merged_value (merged_value),
        .from_second  (from_second),
        .last         (last)
    );

endmodule

// ===== rtl/core/mtsl_checker.sv =====
// Port-level checks for the two-list merge block, bound to its top level.
// Depends on mtsl_pkg and merge_two_sorted_lists_top.
module mtsl_checker #(
    parameter int DEPTH = mtsl_pkg::DEPTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic valid,
    input logic last
);
    import mtsl_pkg::*;

    localparam int RW = $clog2(2 * DEPTH + 1);

    logic [RW-1:0] run_cnt_reg;

    // Count results emitted so far in the current merge run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cnt_reg <= '0;
        else if (valid)
            run_cnt_reg <= last ? '0 : run_cnt_reg + RW'(1);
    end

    // A run emits on consecutive cycles until its last result
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> valid)
        else $error("merge run has a gap before its last result");

    // The back needs a turnaround before the next run
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("result right after the last of a run");

    // last only ever marks a real result
    a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> valid)
        else $error("last asserted without valid");

    // A run never exceeds both lists full
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (run_cnt_reg < RW'(2 * DEPTH)))
        else $error("merge run longer than both lists");

endmodule

bind merge_two_sorted_lists_top mtsl_checker #(
    .DEPTH (DEPTH)
) u_mtsl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .valid (valid),
    .last  (last)
);

// ===== dv/tb_top.sv =====
// Testbench for merge_two_sorted_lists_top: directed and random word streams, scoreboard check.
// Depends on mtsl_pkg and the merge_two_sorted_lists_top RTL; needs nothing else.
module tb_top;

    import mtsl_pkg::*;

    localparam int               LIST_DEPTH  = DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               RANDOM_WORDS = 20;
    localparam int               SETTLE_CYCLES = 20;

    // One merged output word as the predictor expects it
    typedef struct {
        logic signed [31:0] merged_value;
        logic               from_second;
        logic               last;
    } merged_word_t;

    // Flavors of random list content
    typedef enum int {
        VALS_FULL_RANGE,
        VALS_NARROW,
        VALS_EXTREME
    } value_style_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         command;
    logic signed [31:0] value;
    logic               busy;
    logic               valid;
    logic signed [31:0] merged_value;
    logic               from_second;
    logic               last;

    // Predictor state: shadow copies of both lists and their fill counts
    logic signed [31:0] first_vals  [LIST_DEPTH];
    logic signed [31:0] second_vals [LIST_DEPTH];
    int                 first_len;
    int                 second_len;

    merged_word_t       pending_merged[$];
    int                 error_count;
    bit                 gaps_on;
    int                 random_words_sent;

    merge_two_sorted_lists_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .value        (value),
        .busy         (busy),
        .valid        (valid),
        .merged_value (merged_value),
        .from_second  (from_second),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one accepted word to the shadow lists; a merge queues its whole output run.
    task automatic predict_merge_output(input logic [1:0] cmd, input logic signed [31:0] val);
        int           i;
        int           j;
        int           k;
        int           total;
        bit           take_first;
        merged_word_t w;
        case (cmd)
            CMD_PUSH_FIRST:
            begin
                // drop the push silently once the list is full
                if (first_len < LIST_DEPTH)
                begin
                    first_vals[first_len] = val;
                    first_len++;
                end
            end
            CMD_PUSH_SECOND:
            begin
                if (second_len < LIST_DEPTH)
                begin
                    second_vals[second_len] = val;
                    second_len++;
                end
            end
            CMD_MERGE:
            begin
                i = 0;
                j = 0;
                k = 0;
                total = first_len + second_len;
                while (i < first_len || j < second_len)
                begin
                    // strict less-than: a tie hands the second list's head out first
                    if (i < first_len && j < second_len)
                        take_first = first_vals[i] < second_vals[j];
                    else
                        take_first = i < first_len;
                    if (take_first)
                    begin
                        w.merged_value = first_vals[i];
                        w.from_second  = 1'b0;
                        i++;
                    end
                    else
                    begin
                        w.merged_value = second_vals[j];
                        w.from_second  = 1'b1;
                        j++;
                    end
                    k++;
                    w.last = (k == total);
                    pending_merged.push_back(w);
                end
                first_len  = 0;
                second_len = 0;
            end
            default: ;
        endcase
    endtask

    // Drop start and idle with random junk on the payload ports, for as long as the caller asks.
    task automatic hold_off(input int n);
        start   <= 1'b0;
        command <= 2'($urandom_range(0, 3));
        value   <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // Present one word and hold it until the block takes it; leaves start high on return.
    task automatic send_word(input logic [1:0] cmd, input logic signed [31:0] val);
        bit taken;
        if (gaps_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 6));
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        taken = 1'b0;
        while (!taken)
        begin
            // busy is settled mid-cycle; low there means the coming edge takes the word
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        predict_merge_output(cmd, val);
    endtask

    // Stop sending until every predicted result has come out; the clock is always awaited before the first check.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_merged.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_value(input value_style_t style);
        case (style)
            VALS_NARROW:
                return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            VALS_EXTREME:
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return -32'sd1;
                    3:       return 32'sd0;
                    default: return $urandom;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    // Fill a list of n values; keep it ascending by ordered insertion unless told otherwise.
    task automatic build_list(ref logic signed [31:0] vals[$], input int n,
                              input value_style_t style, input bit ascending);
        logic signed [31:0] v;
        int                 pos;
        vals.delete();
        for (int m = 0; m < n; m++)
        begin
            v = pick_value(style);
            pos = vals.size();
            if (ascending)
                while (pos > 0 && vals[pos-1] > v)
                    pos--;
            vals.insert(pos, v);
        end
    endtask

    // Interleave pushes of two lists at random, with stray unused codes, then merge.
    task automatic load_and_merge(input int n_first, input int n_second,
                                  input value_style_t style, input bit ascending);
        logic signed [31:0] list_a[$];
        logic signed [31:0] list_b[$];
        build_list(list_a, n_first, style, ascending);
        build_list(list_b, n_second, style, ascending);
        while (list_a.size() != 0 || list_b.size() != 0)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(CMD_UNUSED, $urandom);
            if (list_b.size() == 0 || (list_a.size() != 0 && $urandom_range(0, 1) == 0))
                send_word(CMD_PUSH_FIRST, list_a.pop_front());
            else
                send_word(CMD_PUSH_SECOND, list_b.pop_front());
            random_words_sent++;
        end
        send_word(CMD_MERGE, $urandom);
        random_words_sent++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_merge();
        send_word(CMD_MERGE, 32'sh5555_aaaa);
        send_word(CMD_MERGE, -32'sd1);
        wait_drained();
    endtask

    task automatic test_single_values();
        send_word(CMD_PUSH_FIRST, 32'sh7fff_ffff);
        send_word(CMD_MERGE, 32'sd0);
        send_word(CMD_PUSH_SECOND, 32'sh8000_0000);
        send_word(CMD_MERGE, 32'sd0);
        wait_drained();
    endtask

    // Ties at both extremes and in the middle; second list runs longer.
    task automatic test_extremes_and_ties();
        send_word(CMD_PUSH_FIRST, 32'sh8000_0000);
        send_word(CMD_PUSH_SECOND, 32'sh8000_0000);
        send_word(CMD_PUSH_FIRST, -32'sd1);
        send_word(CMD_PUSH_SECOND, 32'sd0);
        send_word(CMD_PUSH_FIRST, 32'sd5);
        send_word(CMD_PUSH_SECOND, 32'sd5);
        send_word(CMD_PUSH_SECOND, 32'sh7fff_ffff);
        send_word(CMD_PUSH_FIRST, 32'sh7fff_ffff);
        send_word(CMD_PUSH_SECOND, 32'sh7fff_ffff);
        send_word(CMD_MERGE, 32'sd0);
        wait_drained();
    endtask

    // Lists out of order: output follows the head comparison alone.
    task automatic test_unsorted_lists();
        send_word(CMD_PUSH_FIRST, 32'sd9);
        send_word(CMD_PUSH_FIRST, 32'sd1);
        send_word(CMD_PUSH_SECOND, 32'sd5);
        send_word(CMD_PUSH_SECOND, 32'sd3);
        send_word(CMD_MERGE, 32'sd0);
        wait_drained();
    endtask

    task automatic test_unused_command();
        send_word(CMD_UNUSED, -32'sd1);
        send_word(CMD_PUSH_FIRST, 32'sd7);
        send_word(CMD_UNUSED, 32'sd0);
        send_word(CMD_MERGE, 32'sd0);
        wait_drained();
    endtask

    // One extra push per list beyond DEPTH must vanish; the merge then runs at full length.
    task automatic test_full_lists();
        load_and_merge(LIST_DEPTH + 1, LIST_DEPTH + 1, VALS_FULL_RANGE, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_streams();
        int           n_first;
        int           n_second;
        value_style_t style;
        random_words_sent = 0;
        while (random_words_sent < RANDOM_WORDS)
        begin
            // no idling in the closing stretch
            gaps_on = random_words_sent < RANDOM_WORDS - 8;
            if ($urandom_range(0, 9) == 0)
            begin
                n_first  = $urandom_range(7, 12);
                n_second = $urandom_range(0, 12);
            end
            else
            begin
                n_first  = $urandom_range(0, 6);
                n_second = $urandom_range(0, 6);
            end
            case ($urandom_range(0, 3))
                0:       style = VALS_NARROW;
                1:       style = VALS_EXTREME;
                default: style = VALS_FULL_RANGE;
            endcase
            load_and_merge(n_first, n_second, style, $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------- checker

    // Outputs settle after the rising edge; sample each one-cycle result mid-cycle.
    always @(negedge clk)
    begin
        merged_word_t exp_w;
        if (rst_n && valid)
        begin
            if (pending_merged.size() == 0)
            begin
                $display("%0t: unexpected result value=%h from_second=%b last=%b",
                         $time, merged_value, from_second, last);
                error_count++;
            end
            else
            begin
                exp_w = pending_merged.pop_front();
                if (merged_value !== exp_w.merged_value)
                begin
                    $display("%0t: merged_value expected %h actual %h",
                             $time, exp_w.merged_value, merged_value);
                    error_count++;
                end
                if (from_second !== exp_w.from_second)
                begin
                    $display("%0t: from_second expected %b actual %b",
                             $time, exp_w.from_second, from_second);
                    error_count++;
                end
                if (last !== exp_w.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, exp_w.last, last);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_PUSH_FIRST;
        value       = '0;
        first_len   = 0;
        second_len  = 0;
        error_count = 0;
        gaps_on     = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_merge();
        test_single_values();
        test_extremes_and_ties();
        test_unsorted_lists();
        test_unused_command();
        test_full_lists();
        test_random_streams();

        wait_drained();
        // give a stray late result time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_merged.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_merged.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** merge_two_sorted_lists_top: PASSED **");
        else
            $display("** merge_two_sorted_lists_top: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("** merge_two_sorted_lists_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mtsl_pkg.sv
rtl/core/mtsl_front.sv
rtl/core/mtsl_back.sv
rtl/core/merge_two_sorted_lists_top.sv
rtl/core/mtsl_checker.sv
dv/tb_top.sv
